// ===== src/sync_length_frame_and_cli_line_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame and line parser
// Short forms for the clocked properties used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_AND_CLI_LINE_PARSER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_AND_CLI_LINE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLFCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLFCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// slfcp_pkg
// Shared constants, codes and structures of the frame and line parser.
// ----------------------------------------------------------------------------
package slfcp_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int LINE_MAX      = 128;
    localparam int LINE_W        = 7;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

    // Input function codes.
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_DTR  = 2'd2;

    // Result kinds.
    localparam logic [3:0] KIND_ECHO        = 4'd0;
    localparam logic [3:0] KIND_BANNER      = 4'd1;
    localparam logic [3:0] KIND_PAYLOAD     = 4'd2;
    localparam logic [3:0] KIND_BAD_LENGTH  = 4'd3;
    localparam logic [3:0] KIND_TIMEOUT     = 4'd4;
    localparam logic [3:0] KIND_APPEND      = 4'd5;
    localparam logic [3:0] KIND_ERASE       = 4'd6;
    localparam logic [3:0] KIND_LINE_DONE   = 4'd7;
    localparam logic [3:0] KIND_SESSION_END = 4'd8;

    // Byte values with a meaning to the parser.
    localparam logic [7:0] CHAR_SYNC  = 8'h3C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // What the back end does after an optional timeout result.
    typedef enum logic [1:0] {
        OP_NONE,        // nothing more
        OP_SINGLE,      // one result, fully described by the command
        OP_TEXT_CHAR,   // append then echo
        OP_TEXT_START   // append, optional banner, echo
    } op_t;

    typedef struct packed {
        logic        has_tmo;
        logic [15:0] tmo_len;
        op_t         op;
        logic [3:0]  kind;
        logic [7:0]  data;
        logic [15:0] pos;
        logic [15:0] flen;
        logic        frame_end;
        logic        started;
        logic        banner;
        logic        text_sess;
        logic        connected;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] position;
        logic [15:0] frame_length;
        logic        frame_end;
        logic        session_started;
        logic        text_session;
        logic        connected;
        logic        last;
    } res_t;

    typedef struct packed {
        logic active;
        logic text;
    } sts_t;

endpackage

// ===== src/sync_length_frame_and_cli_line_parser.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_and_cli_line_parser
// Sync-byte, length-prefixed frame parser with a text command-line mode.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ---------------------------------------
//  input     in_valid / in_ready     func, rx_byte
//  output    out_valid / out_ready   kind, data_byte, position, frame_length,
//                                    frame_end, session_started,
//                                    text_session, connected, last
//  config    cfg_valid / cfg_ready   cfg_data (partial timeout in ticks)
//
//  The front end takes one input transaction per cycle while the four-entry
//  command queue has room. The back end emits one result per cycle while the
//  output is not stalled, and an input yields zero to four results.
//  Reset (rst_n low, asynchronous) returns the parser to idle, clears the
//  session, empties the queue and loads the timeout with 2000 ticks.
//  A stalled output backs up into the queue; inputs stall once it fills.
//
`include "sync_length_frame_and_cli_line_parser_assert.svh"

module sync_length_frame_and_cli_line_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  rx_byte,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [7:0]  data_byte,
    output logic [15:0] position,
    output logic [15:0] frame_length,
    output logic        frame_end,
    output logic        session_started,
    output logic        text_session,
    output logic        connected,
    output logic        last
);
    import slfcp_pkg::*;

    logic  in_accept;
    logic  dtr_accept;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    cmd_t  front_cmd;
    cmd_t  q_head;
    sts_t  front_sts;
    res_t  res;

    // The configuration register is a plain write port that is always open.
    assign cfg_ready = 1'b1;

    // Inputs are taken whenever the queue can hold one more command. Inputs
    // that produce no result never occupy a slot.
    assign in_ready  = !q_full;
    assign in_accept = in_valid && in_ready;

    // A disconnect transaction taken in this cycle.
    assign dtr_accept = in_accept && (func == FUNC_DTR);

    slfcp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .func     (func),
        .rx_byte  (rx_byte),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .push     (q_push),
        .cmd      (front_cmd),
        .sts      (front_sts)
    );

    slfcp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    slfcp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind            = res.kind;
    assign data_byte       = res.data_byte;
    assign position        = res.position;
    assign frame_length    = res.frame_length;
    assign frame_end       = res.frame_end;
    assign session_started = res.session_started;
    assign text_session    = res.text_session;
    assign connected       = res.connected;
    assign last            = res.last;

    // A session opens only on a final payload byte or a line end, and either
    // is always the final result of its input.
    `SLFCP_ASSERT_SAME(a_started_is_last, out_valid && session_started, last, "start not last")

    // A text session and a binary connection are never reported together.
    `SLFCP_ASSERT_SAME(a_text_xor_conn, out_valid, !(text_session && connected), "text and binary")

    // A disconnect transaction always leaves the session closed.
    `SLFCP_ASSERT_NEXT(a_dtr_clears, dtr_accept, front_sts == '0, "session survives disconnect")

endmodule

// ===== src/slfcp_front.sv =====
// ----------------------------------------------------------------------------
// slfcp_front
// Accepts input transactions, runs the parser state and emits one command
// per transaction that produces results.
// ----------------------------------------------------------------------------
module slfcp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          func,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output logic                push,
    output slfcp_pkg::cmd_t     cmd,
    output slfcp_pkg::sts_t     sts
);
    import slfcp_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_LEN_LO,
        MODE_LEN_HI,
        MODE_PAYLOAD,
        MODE_TEXT
    } mode_t;

    mode_t              mode_reg,      mode_next;
    logic [15:0]        exp_len_reg,   exp_len_next;
    logic [15:0]        pay_cnt_reg,   pay_cnt_next;
    logic [LINE_W-1:0]  line_len_reg,  line_len_next;
    logic [15:0]        idle_ticks_reg, idle_ticks_next;
    logic               active_reg,    active_next;
    logic               text_reg,      text_next;
    logic               banner_reg,    banner_next;
    logic [15:0]        timeout_reg,   timeout_next;

    mode_t              eff_mode;
    logic               printable;
    logic [15:0]        len_word;
    logic [15:0]        cnt_inc;

    assign printable = rx_byte inside {[CHAR_SPACE:CHAR_TILDE]};
    assign len_word  = {rx_byte, exp_len_reg[7:0]};
    assign cnt_inc   = pay_cnt_reg + 16'd1;
    assign sts       = '{active: active_reg, text: text_reg};

    always_comb
    begin
        mode_next       = mode_reg;
        exp_len_next    = exp_len_reg;
        pay_cnt_next    = pay_cnt_reg;
        line_len_next   = line_len_reg;
        idle_ticks_next = idle_ticks_reg;
        active_next     = active_reg;
        text_next       = text_reg;
        banner_next     = banner_reg;
        timeout_next    = cfg_we ? cfg_data : timeout_reg;
        eff_mode        = mode_reg;
        push            = 1'b0;
        cmd             = '0;
        cmd.op          = OP_NONE;

        if (accept)
        begin
            case (func)
                FUNC_BYTE:
                begin
                    // A stale partial frame or line is dropped before the byte is used.
                    if (mode_reg != MODE_IDLE && idle_ticks_reg > timeout_reg)
                    begin
                        push          = 1'b1;
                        cmd.has_tmo   = 1'b1;
                        cmd.tmo_len   = exp_len_reg;
                        eff_mode      = MODE_IDLE;
                        mode_next     = MODE_IDLE;
                        exp_len_next  = '0;
                        pay_cnt_next  = '0;
                        line_len_next = '0;
                    end

                    case (eff_mode)
                        MODE_LEN_LO:
                        begin
                            exp_len_next = {8'd0, rx_byte};
                            mode_next    = MODE_LEN_HI;
                        end
                        MODE_LEN_HI:
                        begin
                            pay_cnt_next = '0;
                            if (len_word == 16'd0 || len_word > 16'(MAX_FRAME_LEN))
                            begin
                                push         = 1'b1;
                                cmd.op       = OP_SINGLE;
                                cmd.kind     = KIND_BAD_LENGTH;
                                cmd.flen     = len_word;
                                mode_next    = MODE_IDLE;
                                exp_len_next = '0;
                            end
                            else
                            begin
                                exp_len_next = len_word;
                                mode_next    = MODE_PAYLOAD;
                            end
                        end
                        MODE_PAYLOAD:
                        begin
                            push      = 1'b1;
                            cmd.op    = OP_SINGLE;
                            cmd.kind  = KIND_PAYLOAD;
                            cmd.data  = rx_byte;
                            cmd.pos   = pay_cnt_reg;
                            cmd.flen  = exp_len_reg;
                            pay_cnt_next = cnt_inc;
                            if (cnt_inc >= exp_len_reg)
                            begin
                                cmd.frame_end = 1'b1;
                                if (!active_reg)
                                begin
                                    active_next = 1'b1;
                                    text_next   = 1'b0;
                                    cmd.started = 1'b1;
                                end
                                mode_next     = MODE_IDLE;
                                exp_len_next  = '0;
                                pay_cnt_next  = '0;
                                line_len_next = '0;
                            end
                        end
                        MODE_TEXT:
                        begin
                            idle_ticks_next = '0;
                            if (rx_byte == CHAR_LF || rx_byte == CHAR_CR)
                            begin
                                if (line_len_reg != '0)
                                begin
                                    push     = 1'b1;
                                    cmd.op   = OP_SINGLE;
                                    cmd.kind = KIND_LINE_DONE;
                                    cmd.pos  = 16'(line_len_reg);
                                    if (!active_reg)
                                    begin
                                        active_next = 1'b1;
                                        text_next   = 1'b1;
                                        cmd.started = 1'b1;
                                    end
                                end
                                line_len_next = '0;
                                mode_next     = MODE_IDLE;
                            end
                            else if (rx_byte == CHAR_DEL || rx_byte == CHAR_BS)
                            begin
                                if (line_len_reg != '0)
                                begin
                                    line_len_next = line_len_reg - 1'b1;
                                    push          = 1'b1;
                                    cmd.op        = OP_SINGLE;
                                    cmd.kind      = KIND_ERASE;
                                    cmd.pos       = 16'(line_len_reg - 1'b1);
                                end
                            end
                            else if (printable)
                            begin
                                // A full line drops further characters silently.
                                if (line_len_reg < LINE_W'(LINE_MAX - 1))
                                begin
                                    push          = 1'b1;
                                    cmd.op        = OP_TEXT_CHAR;
                                    cmd.data      = rx_byte;
                                    cmd.pos       = 16'(line_len_reg);
                                    line_len_next = line_len_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (rx_byte == CHAR_SYNC)
                            begin
                                mode_next       = MODE_LEN_LO;
                                idle_ticks_next = '0;
                            end
                            else if (printable && (!active_reg || text_reg))
                            begin
                                push            = 1'b1;
                                cmd.op          = OP_TEXT_START;
                                cmd.data        = rx_byte;
                                cmd.banner      = !banner_reg;
                                banner_next     = 1'b1;
                                line_len_next   = LINE_W'(1);
                                idle_ticks_next = '0;
                                mode_next       = MODE_TEXT;
                            end
                        end
                    endcase
                end
                FUNC_TICK:
                begin
                    if (idle_ticks_reg != 16'hFFFF)
                    begin
                        idle_ticks_next = idle_ticks_reg + 16'd1;
                    end
                end
                FUNC_DTR:
                begin
                    active_next     = 1'b0;
                    text_next       = 1'b0;
                    banner_next     = 1'b0;
                    mode_next       = MODE_IDLE;
                    exp_len_next    = '0;
                    pay_cnt_next    = '0;
                    line_len_next   = '0;
                    idle_ticks_next = '0;
                    if (active_reg)
                    begin
                        push     = 1'b1;
                        cmd.op   = OP_SINGLE;
                        cmd.kind = KIND_SESSION_END;
                    end
                end
                default:
                begin
                    // Unused function code: no effect.
                end
            endcase
        end

        cmd.text_sess = text_next;
        cmd.connected = active_next && !text_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            exp_len_reg    <= '0;
            pay_cnt_reg    <= '0;
            line_len_reg   <= '0;
            idle_ticks_reg <= '0;
            active_reg     <= 1'b0;
            text_reg       <= 1'b0;
            banner_reg     <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else
        begin
            mode_reg       <= mode_next;
            exp_len_reg    <= exp_len_next;
            pay_cnt_reg    <= pay_cnt_next;
            line_len_reg   <= line_len_next;
            idle_ticks_reg <= idle_ticks_next;
            active_reg     <= active_next;
            text_reg       <= text_next;
            banner_reg     <= banner_next;
            timeout_reg    <= timeout_next;
        end
    end

endmodule

// ===== src/slfcp_queue.sv =====
// ----------------------------------------------------------------------------
// slfcp_queue
// Small command queue between the parser front end and the result back end.
// ----------------------------------------------------------------------------
module slfcp_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  slfcp_pkg::cmd_t  push_cmd,
    output logic             full,
    input  logic             pop,
    output slfcp_pkg::cmd_t  head,
    output logic             empty
);
    import slfcp_pkg::*;

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW:0]   rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]) &&
                   (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign head  = mem[rd_ptr_reg[QUEUE_AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + ((push && !full) ? 1'b1 : 1'b0);
    assign rd_ptr_next = rd_ptr_reg + ((pop && !empty) ? 1'b1 : 1'b0);

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg[QUEUE_AW-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// ===== src/slfcp_back.sv =====
// ----------------------------------------------------------------------------
// slfcp_back
// Expands each queued command into its results in the output register, one per
// cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module slfcp_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  slfcp_pkg::cmd_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output slfcp_pkg::res_t  res
);
    import slfcp_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_MAIN,
        PH_BANNER,
        PH_ECHO
    } phase_t;

    phase_t  phase_reg, phase_next;
    phase_t  cur;
    logic    load;
    logic    final_res;
    res_t    res_reg, res_next;
    logic    out_valid_reg;

    assign load      = !empty && (!out_valid_reg || out_ready);
    assign pop       = load && final_res;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        cur        = (phase_reg == PH_START && !head.has_tmo) ? PH_MAIN : phase_reg;
        res_next   = '0;
        final_res  = 1'b0;
        phase_next = phase_reg;

        case (cur)
            PH_START:
            begin
                res_next.kind         = KIND_TIMEOUT;
                res_next.frame_length = head.tmo_len;
                final_res             = (head.op == OP_NONE);
                phase_next            = PH_MAIN;
            end
            PH_MAIN:
            begin
                if (head.op == OP_SINGLE)
                begin
                    res_next.kind            = head.kind;
                    res_next.data_byte       = head.data;
                    res_next.position        = head.pos;
                    res_next.frame_length    = head.flen;
                    res_next.frame_end       = head.frame_end;
                    res_next.session_started = head.started;
                    final_res                = 1'b1;
                end
                else
                begin
                    res_next.kind      = KIND_APPEND;
                    res_next.data_byte = head.data;
                    res_next.position  = head.pos;
                    final_res          = (head.op == OP_NONE);
                end
                phase_next = (head.op == OP_TEXT_START && head.banner) ? PH_BANNER : PH_ECHO;
            end
            PH_BANNER:
            begin
                res_next.kind = KIND_BANNER;
                phase_next    = PH_ECHO;
            end
            default:
            begin
                res_next.kind      = KIND_ECHO;
                res_next.data_byte = head.data;
                res_next.position  = head.pos;
                final_res          = 1'b1;
            end
        endcase

        if (final_res)
        begin
            phase_next = PH_START;
        end
        res_next.text_session = head.text_sess;
        res_next.connected    = head.connected;
        res_next.last         = final_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                phase_reg     <= phase_next;
                res_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
